### design/ihp_pkg.sv
// ----------------------------------------------------------------------------
// ihp_pkg: shared types and constants of the IPv4 transport header parser
// Word formats of both channels, captured header state and protocol codes.
// ----------------------------------------------------------------------------
package ihp_pkg;

  // Link header modes held in the configuration register
  localparam logic [1:0] LINK_ETH  = 2'd0;
  localparam logic [1:0] LINK_SLL  = 2'd1;
  localparam logic [1:0] LINK_RAW  = 2'd2;
  localparam logic [1:0] LINK_NONE = 2'd3;

  localparam int          POS_W          = 17;
  localparam logic [16:0] POS_MAX        = 17'h1FFFF;
  localparam logic [16:0] ETH_HDR_LEN    = 17'd14;
  localparam logic [16:0] SLL_HDR_LEN    = 17'd16;
  localparam logic [15:0] IPV4_TYPE      = 16'h0800;
  localparam logic [15:0] IP_MIN_LEN     = 16'd20;
  localparam logic [15:0] TCP_MIN_LEN    = 16'd20;
  localparam logic [15:0] SHORT_L4_MIN   = 16'd8;
  localparam logic [3:0]  IP_VERSION_4   = 4'd4;
  localparam logic [7:0]  PROTO_ICMP     = 8'd1;
  localparam logic [7:0]  PROTO_TCP      = 8'd6;
  localparam logic [7:0]  PROTO_UDP      = 8'd17;

  typedef struct packed {
    logic [7:0]         data_byte;
    logic               last_byte;
    logic signed [63:0] frame_time;
  } in_word_t;

  typedef struct packed {
    logic               ok;
    logic [31:0]        source_address;
    logic [31:0]        dest_address;
    logic [7:0]         proto_number;
    logic [15:0]        source_port;
    logic [15:0]        dest_port;
    logic [5:0]         flag_bits;
    logic [15:0]        payload_offset;
    logic [15:0]        payload_length;
    logic signed [63:0] time_out;
  } out_word_t;

  // Header fields captured for the frame that just completed
  typedef struct packed {
    logic        done;
    logic [15:0] caplen;
    logic [15:0] link_type_word;
    logic [7:0]  ip_first_byte;
    logic [7:0]  proto_byte;
    logic [31:0] saddr;
    logic [31:0] daddr;
    logic [31:0] port_pair;
    logic [15:0] offset_flags;
    logic [63:0] time_val;
  } cap_state_t;

endpackage

### design/ihp_capture.sv
// ----------------------------------------------------------------------------
// ihp_capture: byte position tracking and header field capture
// Latches the header bytes of interest as the frame streams by, one per cycle while bytes are accepted.
// ----------------------------------------------------------------------------
module ihp_capture #(
  parameter int MAX_FRAME_LEN = 65535
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 accept,
  input  logic                 hold,
  input  ihp_pkg::in_word_t    in_word,
  input  logic [1:0]           link_mode,
  output ihp_pkg::cap_state_t  state
);

  localparam logic [16:0] MAX_LEN = 17'(MAX_FRAME_LEN);

  logic [16:0]         pos_r, pos_nxt;
  ihp_pkg::cap_state_t st_r, st_nxt;

  logic [16:0] hdr;
  logic        cap_en;
  logic [16:0] rel;
  logic [16:0] rel4;
  logic [16:0] ihl;
  logic [16:0] pos_inc;
  logic [7:0]  b;

  function automatic logic [31:0] put_byte(input logic [31:0] w, input logic [1:0] idx,
                                           input logic [7:0] v);
    logic [31:0] r;
    r = w;
    r[5'(24 - 8 * int'(idx)) +: 8] = v;
    return r;
  endfunction

  always_comb begin
    st_nxt  = st_r;
    pos_nxt = pos_r;
    b       = in_word.data_byte;
    hdr     = '0;
    cap_en  = 1'b1;
    rel     = '0;
    rel4    = '0;
    ihl     = '0;
    pos_inc = (pos_r == ihp_pkg::POS_MAX) ? pos_r : pos_r + 17'd1;

    unique case (link_mode)
      ihp_pkg::LINK_ETH: hdr = ihp_pkg::ETH_HDR_LEN;
      ihp_pkg::LINK_SLL: hdr = ihp_pkg::SLL_HDR_LEN;
      ihp_pkg::LINK_RAW: hdr = '0;
      default:           cap_en = 1'b0;
    endcase

    if (!hold) begin
      st_nxt.done = accept && in_word.last_byte;
    end

    if (accept) begin
      if (pos_r == '0) begin
        st_nxt.time_val = in_word.frame_time;
      end
      if (cap_en && link_mode != ihp_pkg::LINK_RAW) begin
        if (pos_r == hdr - 17'd2) st_nxt.link_type_word[15:8] = b;
        if (pos_r == hdr - 17'd1) st_nxt.link_type_word[7:0]  = b;
      end
      if (cap_en && pos_r >= hdr) begin
        rel = pos_r - hdr;
        if (rel == 17'd0) begin
          st_nxt.ip_first_byte = b;
        end else if (rel == 17'd9) begin
          st_nxt.proto_byte = b;
        end else if (rel >= 17'd12 && rel < 17'd16) begin
          st_nxt.saddr = put_byte(st_r.saddr, rel[1:0], b);
        end else if (rel >= 17'd16 && rel < 17'd20) begin
          st_nxt.daddr = put_byte(st_r.daddr, rel[1:0], b);
        end
        // IHL from the byte as just updated
        ihl = {11'd0, st_nxt.ip_first_byte[3:0], 2'b00};
        if (ihl >= 17'(ihp_pkg::IP_MIN_LEN) && rel >= ihl) begin
          rel4 = rel - ihl;
          if (rel4 < 17'd4) begin
            st_nxt.port_pair = put_byte(st_r.port_pair, rel4[1:0], b);
          end else if (rel4 == 17'd12) begin
            st_nxt.offset_flags[15:8] = b;
          end else if (rel4 == 17'd13) begin
            st_nxt.offset_flags[7:0] = b;
          end
        end
      end
      if (in_word.last_byte) begin
        st_nxt.caplen = (pos_inc > MAX_LEN) ? MAX_LEN[15:0] : pos_inc[15:0];
        pos_nxt       = '0;
      end else begin
        pos_nxt = pos_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
      st_r  <= '0;
    end else begin
      pos_r <= pos_nxt;
      st_r  <= st_nxt;
    end
  end

  assign state = st_r;

endmodule

### design/ihp_finish.sv
// ----------------------------------------------------------------------------
// ihp_finish: frame validation and result formatting
// Checks the captured headers against the captured length, builds the result.
// ----------------------------------------------------------------------------
module ihp_finish (
  input  ihp_pkg::cap_state_t state,
  input  logic [1:0]          link_mode,
  output ihp_pkg::out_word_t  result
);

  logic [15:0] hdr;
  logic [15:0] l3;
  logic [15:0] ihl;
  logic [15:0] l4;
  logic [15:0] doff;
  logic [15:0] off;
  logic [15:0] sp;
  logic [15:0] dp;
  logic [5:0]  fl;
  logic        good;

  always_comb begin
    good = 1'b1;
    hdr  = '0;
    sp   = '0;
    dp   = '0;
    fl   = '0;
    unique case (link_mode)
      ihp_pkg::LINK_ETH: hdr = ihp_pkg::ETH_HDR_LEN[15:0];
      ihp_pkg::LINK_SLL: hdr = ihp_pkg::SLL_HDR_LEN[15:0];
      ihp_pkg::LINK_RAW: hdr = '0;
      default:           good = 1'b0;
    endcase

    l3   = state.caplen - hdr;
    ihl  = {10'd0, state.ip_first_byte[3:0], 2'b00};
    l4   = l3 - ihl;
    doff = {10'd0, state.offset_flags[15:12], 2'b00};
    off  = hdr + ihl;

    if (state.caplen < hdr) good = 1'b0;
    if (link_mode != ihp_pkg::LINK_RAW && state.link_type_word != ihp_pkg::IPV4_TYPE)
      good = 1'b0;
    if (l3 < ihp_pkg::IP_MIN_LEN) good = 1'b0;
    if (state.ip_first_byte[7:4] != ihp_pkg::IP_VERSION_4) good = 1'b0;
    if (ihl < ihp_pkg::IP_MIN_LEN || ihl > l3) good = 1'b0;

    case (state.proto_byte)
      ihp_pkg::PROTO_TCP: begin
        if (l4 < ihp_pkg::TCP_MIN_LEN) good = 1'b0;
        if (doff < ihp_pkg::TCP_MIN_LEN || doff > l4) good = 1'b0;
        sp  = state.port_pair[31:16];
        dp  = state.port_pair[15:0];
        fl  = state.offset_flags[5:0];
        off = off + doff;
      end
      ihp_pkg::PROTO_UDP: begin
        if (l4 < ihp_pkg::SHORT_L4_MIN) good = 1'b0;
        sp  = state.port_pair[31:16];
        dp  = state.port_pair[15:0];
        off = off + ihp_pkg::SHORT_L4_MIN;
      end
      ihp_pkg::PROTO_ICMP: begin
        if (l4 < ihp_pkg::SHORT_L4_MIN) good = 1'b0;
      end
      default: good = 1'b0;
    endcase

    result          = '0;
    result.time_out = state.time_val;
    if (good) begin
      result.ok             = 1'b1;
      result.source_address = state.saddr;
      result.dest_address   = state.daddr;
      result.proto_number   = state.proto_byte;
      result.source_port    = sp;
      result.dest_port      = dp;
      result.flag_bits      = fl;
      result.payload_offset = off;
      result.payload_length = state.caplen - off;
    end
  end

endmodule

### design/ipv4_l4_header_parser.sv
// ----------------------------------------------------------------------------
// ipv4_l4_header_parser: streaming IPv4 TCP/UDP/ICMP header parser
// Takes a captured frame one byte per word and returns one decode per frame.
// ----------------------------------------------------------------------------
// Usage
//   Input channel (in_valid/in_ready/in_data): one frame byte per word, the
//   final byte marked by last_byte. frame_time is sampled on the first byte.
//   Result channel (out_valid/out_ready/out_data): one word per frame, sent
//   after the last byte. ok low means the frame failed; every other field is
//   then zero except time_out.
//   Configuration (cfg_we/cfg_data): selects the link header (Ethernet,
//   cooked capture, raw IPv4 or unsupported). Write it only while idle.
//   Throughput: one byte per cycle while input is not stalled. The header capture
//   registers are loaded directly from the input word; the check logic then feeds
//   the result register, which loads and raises out_valid unless stalled.
//   Stall: the result register holds while out_ready is low and bytes keep
//   flowing; input stops only when a second finished frame is waiting behind
//   the held result (for instance back-to-back single-byte frames).
//   Reset: rst_n low clears the position counter, the captured header state,
//   the link mode (Ethernet) and the result valid flag.
// ----------------------------------------------------------------------------
module ipv4_l4_header_parser #(
  parameter int MAX_FRAME_LEN = 65535
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  ihp_pkg::in_word_t   in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output ihp_pkg::out_word_t  out_data,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_data
);

  logic [1:0]          link_mode_r, link_mode_nxt;
  logic                out_valid_r, out_valid_nxt;
  ihp_pkg::out_word_t  out_data_r, out_data_nxt;
  ihp_pkg::cap_state_t cap_state;
  ihp_pkg::out_word_t  result;
  logic                stall;
  logic                accept;
  logic                load;

  // Hold everything when a finished frame waits behind an unread result
  assign stall    = cap_state.done && out_valid_r && !out_ready;
  assign in_ready = !stall;
  assign accept   = in_valid && in_ready;
  assign load     = cap_state.done && !stall;

  ihp_capture #(
    .MAX_FRAME_LEN(MAX_FRAME_LEN)
  ) u_capture (
    .clk      (clk),
    .rst_n    (rst_n),
    .accept   (accept),
    .hold     (stall),
    .in_word  (in_data),
    .link_mode(link_mode_r),
    .state    (cap_state)
  );

  ihp_finish u_finish (
    .state    (cap_state),
    .link_mode(link_mode_r),
    .result   (result)
  );

  always_comb begin
    link_mode_nxt = cfg_we ? cfg_data : link_mode_r;
    out_data_nxt  = load ? result : out_data_r;
    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      link_mode_r <= ihp_pkg::LINK_ETH;
      out_valid_r <= 1'b0;
    end else begin
      link_mode_r <= link_mode_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Result payload carries no reset
  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

### design/ihp_checker.sv
// ----------------------------------------------------------------------------
// ihp_checker: port-level checks for the IPv4 transport header parser
// Watches the result channel for stability and result-word consistency.
// ----------------------------------------------------------------------------
module ihp_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic               out_ready,
  input ihp_pkg::out_word_t out_data
);

  // Stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result word changed while stalled");

  // No result in the cycle right after reset
  a_reset_idle: assert property (@(posedge clk)
    rst_n && !$past(rst_n) |-> !out_valid)
    else $error("result valid right after reset");

  // Failed frame: only time_out may be nonzero
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.ok |-> out_data.source_address == '0 &&
      out_data.dest_address == '0 && out_data.proto_number == '0 &&
      out_data.source_port == '0 && out_data.dest_port == '0 &&
      out_data.flag_bits == '0 && out_data.payload_offset == '0 &&
      out_data.payload_length == '0)
    else $error("failed frame carries nonzero fields");

  // Good frame: protocol is one that decodes
  a_ok_proto: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.ok |-> out_data.proto_number == ihp_pkg::PROTO_TCP ||
      out_data.proto_number == ihp_pkg::PROTO_UDP ||
      out_data.proto_number == ihp_pkg::PROTO_ICMP)
    else $error("ok with unsupported protocol");

  // Flags only for TCP, ports never for ICMP
  a_flags_ports: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.ok && out_data.proto_number != ihp_pkg::PROTO_TCP |->
      out_data.flag_bits == '0 &&
      (out_data.proto_number != ihp_pkg::PROTO_ICMP ||
       (out_data.source_port == '0 && out_data.dest_port == '0)))
    else $error("flags or ports set for wrong protocol");

endmodule

bind ipv4_l4_header_parser ihp_checker u_ihp_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .out_valid(out_valid),
  .out_ready(out_ready),
  .out_data (out_data)
);

### tb/sv/ipv4_l4_header_parser_test.sv
// ----------------------------------------------------------------------------
// ipv4_l4_header_parser_test: self-checking bench for the IPv4 header parser
// Feeds whole captured frames byte by byte under every link mode, keeps a
// shadow of the header capture, predicts one decode per frame and checks
// every result word field by field, with random gaps and stalls on both sides.
// ----------------------------------------------------------------------------
module ipv4_l4_header_parser_test;
  import ihp_pkg::*;

  localparam int MAX_FRAME_LEN = 65535;
  localparam int SETTLE        = 8;     // cycles of quiet before a link mode write
  localparam int TAIL_CYCLES   = 16;
  localparam int HOLD_SPAN     = 400;   // long receiver hold-off
  localparam int RANDOM_BYTES  = 350;
  localparam int RANDOM_FRAMES = 6;

  // Byte offsets inside the IP and TCP headers
  localparam int PROTO_AT      = 9;
  localparam int SRC_AT        = 12;
  localparam int DST_AT        = 16;
  localparam int TCP_DOFF_AT   = 12;
  localparam int TCP_FLAGS_AT  = 13;

  localparam logic [63:0] STAMP_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] STAMP_MIN = 64'h8000_0000_0000_0000;

  typedef logic [7:0] octet_q_t[$];

  typedef enum {STEP_BYTE, STEP_CFG, STEP_DRAIN, STEP_HOLD} feed_kind_t;

  typedef struct {
    feed_kind_t kind;
    in_word_t   word;
    logic [1:0] mode;
    int         gap;
  } feed_step_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  in_word_t   in_data = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  out_word_t  out_data;
  logic       cfg_we = 1'b0;
  logic [1:0] cfg_data = LINK_ETH;

  ipv4_l4_header_parser #(
    .MAX_FRAME_LEN(MAX_FRAME_LEN)
  ) u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data)
  );

  always #4 clk = ~clk;

  // Stimulus queue, expected decodes and run bookkeeping
  feed_step_t feed_q[$];
  out_word_t  verdicts_due[$];
  int         mismatch_count = 0;
  int         hold_requests = 0;
  longint     cycle_budget = 0;
  longint     cycle_limit = 64'h7FFF_FFFF;
  longint     cycle_count = 0;

  // Shadow of the header capture registers
  logic [1:0]       link_mode_now = LINK_ETH;
  logic [POS_W-1:0] byte_count = '0;
  logic [15:0]      link_word = '0;
  logic [7:0]       ver_ihl = '0;
  logic [7:0]       proto_reg = '0;
  logic [31:0]      src_reg = '0;
  logic [31:0]      dst_reg = '0;
  logic [31:0]      ports_reg = '0;
  logic [15:0]      off_flags_reg = '0;
  logic [63:0]      stamp_reg = '0;

  // --------------------------------------------------------------------------
  // Decode prediction
  // --------------------------------------------------------------------------

  // Decide the result word of the frame that just closed, from the shadow
  // capture and the captured length (already clamped to MAX_FRAME_LEN).
  function automatic out_word_t frame_verdict(input int caplen);
    out_word_t v;
    int        hdr;
    int        l3;
    int        ihl;
    int        l4;
    int        off;
    int        doff;
    v = '0;
    v.time_out = stamp_reg;
    case (link_mode_now)
      LINK_ETH: hdr = ETH_HDR_LEN;
      LINK_SLL: hdr = SLL_HDR_LEN;
      LINK_RAW: hdr = 0;
      default:  return v;
    endcase
    if (caplen < hdr) return v;
    if (link_mode_now != LINK_RAW && link_word != IPV4_TYPE) return v;
    l3 = caplen - hdr;
    if (l3 < IP_MIN_LEN) return v;
    if (ver_ihl[7:4] != IP_VERSION_4) return v;
    ihl = ver_ihl[3:0] * 4;
    if (ihl < IP_MIN_LEN || ihl > l3) return v;
    l4 = l3 - ihl;
    off = hdr + ihl;
    if (proto_reg == PROTO_TCP) begin
      if (l4 < TCP_MIN_LEN) return v;
      doff = off_flags_reg[15:12] * 4;
      if (doff < TCP_MIN_LEN || doff > l4) return v;
      v.source_port = ports_reg[31:16];
      v.dest_port = ports_reg[15:0];
      v.flag_bits = off_flags_reg[5:0];
      off += doff;
    end else if (proto_reg == PROTO_UDP) begin
      if (l4 < SHORT_L4_MIN) return v;
      v.source_port = ports_reg[31:16];
      v.dest_port = ports_reg[15:0];
      off += SHORT_L4_MIN;
    end else if (proto_reg == PROTO_ICMP) begin
      if (l4 < SHORT_L4_MIN) return v;
    end else begin
      return v;
    end
    v.ok = 1'b1;
    v.source_address = src_reg;
    v.dest_address = dst_reg;
    v.proto_number = proto_reg;
    v.payload_offset = off[15:0];
    v.payload_length = 16'(caplen - off);
    return v;
  endfunction

  // Capture one accepted byte into the shadow registers; on the last byte
  // queue the decode and restart the position count.
  task automatic track_header_byte(input in_word_t w);
    int         at;
    int         hdr;
    int         rel;
    int         ihl;
    logic [7:0] b;
    b = w.data_byte;
    at = byte_count;
    if (at == 0) stamp_reg = w.frame_time;
    case (link_mode_now)
      LINK_ETH: hdr = ETH_HDR_LEN;
      LINK_SLL: hdr = SLL_HDR_LEN;
      LINK_RAW: hdr = 0;
      default:  hdr = -1;
    endcase
    // The link type word sits in the last two bytes of the link header
    if (hdr > 0) begin
      if (at == hdr - 2) link_word[15:8] = b;
      if (at == hdr - 1) link_word[7:0] = b;
    end
    if (hdr >= 0 && at >= hdr) begin
      rel = at - hdr;
      if (rel == 0) ver_ihl = b;
      else if (rel == PROTO_AT) proto_reg = b;
      else if (rel >= SRC_AT && rel < SRC_AT + 4) src_reg[8*(SRC_AT+3-rel) +: 8] = b;
      else if (rel >= DST_AT && rel < DST_AT + 4) dst_reg[8*(DST_AT+3-rel) +: 8] = b;
      ihl = ver_ihl[3:0] * 4;
      // Transport bytes count only behind a sane IHL
      if (ihl >= IP_MIN_LEN && rel >= ihl) begin
        rel -= ihl;
        if (rel < 4) ports_reg[8*(3-rel) +: 8] = b;
        else if (rel == TCP_DOFF_AT) off_flags_reg[15:8] = b;
        else if (rel == TCP_FLAGS_AT) off_flags_reg[7:0] = b;
      end
    end
    if (byte_count != POS_MAX) byte_count++;
    if (w.last_byte) begin
      verdicts_due.push_back(frame_verdict(byte_count > MAX_FRAME_LEN ?
                                           MAX_FRAME_LEN : int'(byte_count)));
      byte_count = '0;
    end
  endtask

  // --------------------------------------------------------------------------
  // Frame building
  // --------------------------------------------------------------------------

  function automatic logic [7:0] rand_octet();
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [63:0] rand_stamp();
    return {$urandom, $urandom};
  endfunction

  // Idle cycles before a word: 0 = back to back, 1 = full random, else sparse
  function automatic int draw_gap(input int pace);
    if (pace == 0) return 0;
    if (pace == 1) return $urandom_range(0, 11);
    return ($urandom_range(0, 7) == 0) ? $urandom_range(1, 11) : 0;
  endfunction

  // Link header length as laid out by the builder; unsupported mode gets
  // an Ethernet layout so the frame would pass anywhere else
  function automatic int link_len(input logic [1:0] mode);
    if (mode == LINK_SLL) return SLL_HDR_LEN;
    if (mode == LINK_RAW) return 0;
    return ETH_HDR_LEN;
  endfunction

  function automatic octet_q_t build_frame(input logic [1:0] mode, input logic [7:0] proto,
                                           input logic [3:0] ihl, input logic [3:0] doff,
                                           input int pay_len);
    octet_q_t f;
    int       ip_len;
    int       l4_len;
    ip_len = (ihl > 5) ? ihl * 4 : IP_MIN_LEN;
    l4_len = (proto == PROTO_TCP) ? ((doff > 5) ? doff * 4 : TCP_MIN_LEN) : SHORT_L4_MIN;
    if (mode != LINK_RAW) begin
      repeat (link_len(mode) - 2) f.push_back(rand_octet());
      f.push_back(IPV4_TYPE[15:8]);
      f.push_back(IPV4_TYPE[7:0]);
    end
    for (int i = 0; i < ip_len; i++) begin
      if (i == 0) f.push_back({IP_VERSION_4, ihl});
      else if (i == PROTO_AT) f.push_back(proto);
      else f.push_back(rand_octet());
    end
    for (int i = 0; i < l4_len; i++) begin
      if (proto == PROTO_TCP && i == TCP_DOFF_AT) f.push_back({doff, 4'(rand_octet())});
      else f.push_back(rand_octet());
    end
    repeat (pay_len) f.push_back(rand_octet());
    return f;
  endfunction

  function automatic octet_q_t clip(input octet_q_t f, input int n);
    while (f.size() > n) void'(f.pop_back());
    return f;
  endfunction

  function automatic octet_q_t noise(input int n, input int fill);
    octet_q_t f;
    repeat (n) f.push_back(fill < 0 ? rand_octet() : fill[7:0]);
    return f;
  endfunction

  // Queue the bytes of a frame (or part of one); the first byte carries the
  // stamp, the rest random times that the block must ignore
  task automatic queue_bytes(input octet_q_t f, input logic [63:0] stamp, input int pace,
                             input bit end_mark);
    feed_step_t s;
    foreach (f[i]) begin
      s.kind = STEP_BYTE;
      s.mode = LINK_ETH;
      s.word.data_byte = f[i];
      s.word.last_byte = end_mark && (i == f.size() - 1);
      s.word.frame_time = (i == 0) ? stamp : rand_stamp();
      s.gap = draw_gap(pace);
      cycle_budget += s.gap + 1;
      feed_q.push_back(s);
    end
    if (end_mark) cycle_budget += 16;
  endtask

  task automatic queue_frame(input octet_q_t f, input int pace);
    queue_bytes(f, rand_stamp(), pace, 1'b1);
  endtask

  task automatic queue_control(input feed_kind_t kind, input logic [1:0] mode);
    feed_step_t s;
    s.kind = kind;
    s.mode = mode;
    s.word = '0;
    s.gap = 0;
    cycle_budget += (kind == STEP_HOLD) ? HOLD_SPAN : SETTLE + 16;
    feed_q.push_back(s);
  endtask

  // --------------------------------------------------------------------------
  // Input driver: one queue entry at a time; link mode writes and pauses
  // wait until every decode is back and the pipe has settled.
  // --------------------------------------------------------------------------
  int idle_span = 0;
  int quiet_span = 0;

  always @(posedge clk) begin
    logic       offer;
    logic       we_next;
    feed_step_t head;
    offer = in_valid;
    we_next = 1'b0;
    if (!rst_n) begin
      offer = 1'b0;
      idle_span = 0;
      quiet_span = 0;
    end else begin
      if (in_valid && in_ready) begin
        track_header_byte(in_data);
        offer = 1'b0;
      end
      if (!offer && verdicts_due.size() == 0) quiet_span++;
      else quiet_span = 0;
      if (!offer && feed_q.size() != 0) begin
        head = feed_q[0];
        case (head.kind)
          STEP_BYTE: begin
            // Hold off for the drawn gap, then present the word
            if (idle_span >= head.gap) begin
              in_data <= head.word;
              offer = 1'b1;
              idle_span = 0;
              void'(feed_q.pop_front());
            end else begin
              idle_span++;
            end
          end
          STEP_CFG: begin
            if (quiet_span >= SETTLE) begin
              we_next = 1'b1;
              cfg_data <= head.mode;
              link_mode_now = head.mode;
              quiet_span = 0;
              void'(feed_q.pop_front());
            end
          end
          STEP_DRAIN: begin
            if (quiet_span >= SETTLE) void'(feed_q.pop_front());
          end
          default: begin
            // Ask the receiver for a long hold-off and keep sending
            hold_requests++;
            void'(feed_q.pop_front());
          end
        endcase
      end
    end
    in_valid <= offer;
    cfg_we <= we_next;
  end

  // --------------------------------------------------------------------------
  // Result monitor: check each accepted word against the oldest decode and
  // draw a stall after it; a hold request blocks ready while its hold-off counter runs down.
  // --------------------------------------------------------------------------
  int holds_taken = 0;
  int hold_left = 0;
  int stall_left = 0;
  int rx_pace = 1;
  int rx_words = 0;

  task automatic compare_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatch_count++;
    end
  endtask

  always @(posedge clk) begin
    out_word_t want;
    logic      ready_next;
    ready_next = 1'b0;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (verdicts_due.size() == 0) begin
          $error("result word with no frame pending: %h", out_data);
          mismatch_count++;
        end else begin
          want = verdicts_due.pop_front();
          compare_field("ok", 64'(want.ok), 64'(out_data.ok));
          compare_field("source_address", 64'(want.source_address),
                        64'(out_data.source_address));
          compare_field("dest_address", 64'(want.dest_address), 64'(out_data.dest_address));
          compare_field("proto_number", 64'(want.proto_number), 64'(out_data.proto_number));
          compare_field("source_port", 64'(want.source_port), 64'(out_data.source_port));
          compare_field("dest_port", 64'(want.dest_port), 64'(out_data.dest_port));
          compare_field("flag_bits", 64'(want.flag_bits), 64'(out_data.flag_bits));
          compare_field("payload_offset", 64'(want.payload_offset),
                        64'(out_data.payload_offset));
          compare_field("payload_length", 64'(want.payload_length),
                        64'(out_data.payload_length));
          compare_field("time_out", 64'(want.time_out), 64'(out_data.time_out));
        end
        rx_words++;
        // Change stall style now and then so calm stretches occur too
        if (rx_words % 16 == 0) rx_pace = $urandom_range(0, 2);
        stall_left = draw_gap(rx_pace);
      end
      if (holds_taken != hold_requests) begin
        holds_taken++;
        hold_left = HOLD_SPAN;
      end
      if (hold_left > 0) hold_left--;
      else if (stall_left > 0) stall_left--;
      else ready_next = 1'b1;
    end
    out_ready <= ready_next;
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > cycle_limit) begin
      $error("run did not finish within %0d cycles", cycle_limit);
      $display("end of test: mismatches");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus and end of run
  // --------------------------------------------------------------------------
  initial begin
    octet_q_t   f;
    octet_q_t   tail;
    logic [1:0] build_mode;
    logic [7:0] proto;
    logic [3:0] ihl;
    logic [3:0] doff;
    logic [3:0] nib;
    int         lh;
    int         pay;
    int         frames;
    int         rand_bytes;

    // Reset mode is Ethernet: one frame of each protocol, timestamp extremes
    queue_bytes(build_frame(LINK_ETH, PROTO_TCP, 5, 5, 6), STAMP_MAX, 1, 1'b1);
    queue_bytes(build_frame(LINK_ETH, PROTO_UDP, 5, 5, 0), STAMP_MIN, 1, 1'b1);
    queue_frame(build_frame(LINK_ETH, PROTO_ICMP, 5, 5, 3), 2);
    // Unknown protocol, wrong EtherType, wrong IP version
    queue_frame(build_frame(LINK_ETH, 8'hFF, 5, 5, 4), 1);
    f = build_frame(LINK_ETH, PROTO_TCP, 5, 5, 2);
    f[ETH_HDR_LEN-2] = 8'h86;
    f[ETH_HDR_LEN-1] = 8'hDD;
    queue_frame(f, 0);
    f = build_frame(LINK_ETH, PROTO_UDP, 5, 5, 2);
    f[ETH_HDR_LEN] = {4'd6, 4'd5};
    queue_frame(f, 1);
    // Bogus IHL, largest IHL and data offset, IHL beyond the captured bytes
    queue_frame(build_frame(LINK_ETH, PROTO_TCP, 4, 5, 8), 1);
    queue_frame(build_frame(LINK_ETH, PROTO_TCP, 15, 15, 2), 2);
    queue_frame(clip(build_frame(LINK_ETH, PROTO_UDP, 15, 5, 0), ETH_HDR_LEN + 40), 1);
    // TCP: data offset too small, exact fit, transport header cut short
    queue_frame(build_frame(LINK_ETH, PROTO_TCP, 5, 3, 10), 1);
    queue_frame(build_frame(LINK_ETH, PROTO_TCP, 5, 5, 0), 0);
    queue_frame(clip(build_frame(LINK_ETH, PROTO_TCP, 5, 5, 0), ETH_HDR_LEN + 39), 1);
    // UDP exactly eight bytes, then one short
    queue_frame(build_frame(LINK_ETH, PROTO_UDP, 5, 5, 0), 1);
    queue_frame(clip(build_frame(LINK_ETH, PROTO_UDP, 5, 5, 0), ETH_HDR_LEN + 27), 1);
    // Single byte, frame shorter than the link header, all-zero noise
    queue_frame(noise(1, -1), 1);
    queue_frame(noise(13, 255), 0);
    queue_frame(noise(40, 0), 0);

    queue_control(STEP_CFG, LINK_SLL);
    queue_frame(build_frame(LINK_SLL, PROTO_TCP, 6, 7, 5), 1);
    queue_frame(build_frame(LINK_SLL, PROTO_UDP, 5, 5, 9), 2);

    queue_control(STEP_CFG, LINK_RAW);
    queue_frame(build_frame(LINK_RAW, PROTO_ICMP, 5, 5, 0), 1);
    queue_frame(build_frame(LINK_RAW, PROTO_TCP, 5, 6, 4), 1);
    queue_frame(clip(build_frame(LINK_RAW, PROTO_UDP, 5, 5, 0), 19), 1);

    // Unsupported mode fails even a perfect frame
    queue_control(STEP_CFG, LINK_NONE);
    queue_frame(build_frame(LINK_ETH, PROTO_TCP, 5, 5, 4), 1);

    // Switch mode in the middle of a frame once the pipe is quiet
    queue_control(STEP_CFG, LINK_ETH);
    f = build_frame(LINK_ETH, PROTO_UDP, 5, 5, 4);
    tail = f;
    repeat (20) void'(tail.pop_front());
    queue_bytes(clip(f, 20), rand_stamp(), 1, 1'b0);
    queue_control(STEP_CFG, LINK_RAW);
    queue_bytes(tail, rand_stamp(), 1, 1'b1);

    // Back up the pipe: receiver holds off while single-byte frames stream in
    queue_control(STEP_CFG, LINK_ETH);
    queue_control(STEP_HOLD, LINK_ETH);
    repeat (24) queue_frame(noise(1, -1), 0);
    queue_control(STEP_DRAIN, LINK_ETH);

    // Random part: mostly well-formed frames under the current mode, the
    // rest broken or plain noise; mode changes every few frames
    build_mode = LINK_ETH;
    frames = 0;
    rand_bytes = 0;
    while (rand_bytes < RANDOM_BYTES || frames < RANDOM_FRAMES) begin
      if (frames % 4 == 3) begin
        if ($urandom_range(0, 3) == 0) begin
          queue_control(STEP_DRAIN, build_mode);
        end else begin
          build_mode = ($urandom_range(0, 7) == 0) ? LINK_NONE : 2'($urandom_range(0, 2));
          queue_control(STEP_CFG, build_mode);
        end
      end
      case ($urandom_range(0, 2))
        0:       proto = PROTO_TCP;
        1:       proto = PROTO_UDP;
        default: proto = PROTO_ICMP;
      endcase
      ihl = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(6, 15)) : 4'd5;
      doff = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(6, 15)) : 4'd5;
      pay = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 60) : $urandom_range(0, 12);
      f = build_frame(build_mode, proto, ihl, doff, pay);
      lh = link_len(build_mode);
      if ($urandom_range(0, 9) >= 7) begin
        case ($urandom_range(0, 6))
          0: f = clip(f, $urandom_range(1, f.size()));
          1: begin
            if (lh > 0) f[lh-1] = f[lh-1] ^ rand_octet() | 8'h01;
            else f = clip(f, $urandom_range(1, f.size()));
          end
          2: begin
            nib = 4'($urandom_range(0, 15));
            if (nib == IP_VERSION_4) nib = 4'd6;
            f[lh] = {nib, f[lh][3:0]};
          end
          3: f[lh] = {IP_VERSION_4, 4'($urandom_range(0, 4))};
          4: f[lh+PROTO_AT] = rand_octet();
          5: f = build_frame(build_mode, PROTO_TCP, ihl, 4'($urandom_range(0, 4)), pay);
          default: f = noise($urandom_range(1, 40), -1);
        endcase
      end
      queue_frame(f, $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 2));
      rand_bytes += f.size();
      frames++;
    end
    cycle_limit = 4 * cycle_budget + 20000;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Wait for the stimulus to go out and every decode to come back; look
    // at the falling edge so the driver and monitor updates have settled
    while (feed_q.size() != 0 || in_valid || verdicts_due.size() != 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
